FILE: sv/learning_switch_forwarder_unit_defines.svh
// Assertion macros shared by the learning switch forwarder RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef LEARNING_SWITCH_FORWARDER_UNIT_DEFINES_SVH
`define LEARNING_SWITCH_FORWARDER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset
`define LSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lsf assertion failed (same cycle)");

// Next-cycle implication, checked outside reset
`define LSF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lsf assertion failed (next cycle)");

`else

`define LSF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LSF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/lsf_pkg.sv
// Shared constants and types for the learning switch forwarder.
// No dependencies; imported by every lsf module except lsf_ram.
package lsf_pkg;

	// Table and port sizing
	localparam int TABLE_DEPTH = 64;
	localparam int NUM_PORTS   = 16;
	localparam int ID_WIDTH    = 16;
	localparam int PORT_W      = 4;
	localparam int MASK_W      = 16;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

	// Request queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef enum logic {
		OP_FORWARD = 1'b0,
		OP_STATIC  = 1'b1
	} op_t;

	// Classified request handed from front to back
	typedef struct packed {
		op_t                 op;
		logic [ID_WIDTH-1:0] src;
		logic [ID_WIDTH-1:0] dst;
		logic [PORT_W-1:0]   port;
		logic [MASK_W-1:0]   fmask;
	} item_t;

	// One table entry as stored in RAM
	typedef struct packed {
		logic [ID_WIDTH-1:0] id;
		logic [PORT_W-1:0]   port;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [PORT_W-1:0] out_port;
		logic              flood;
		logic [MASK_W-1:0] flood_mask;
		logic              learned;
		logic              table_full;
	} result_t;

	typedef struct packed {
		logic               busy;
		logic [COUNT_W-1:0] entry_count;
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} bk_state_t;

endpackage

FILE: sv/lsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/lsf_front.sv
// Front end: takes requests off the input channel and classifies them.
// Depends on lsf_pkg; feeds lsf_queue.
module lsf_front (
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic [lsf_pkg::ID_WIDTH-1:0] src_id,
	input  logic [lsf_pkg::ID_WIDTH-1:0] dest_id,
	input  logic [lsf_pkg::PORT_W-1:0]   in_port,
	input  logic [lsf_pkg::MASK_W-1:0]   port_mask,
	input  logic                         q_full,
	output logic                         push,
	output lsf_pkg::item_t               push_item
);
	import lsf_pkg::*;

	logic [MASK_W-1:0] fmask;

	// Stall only on a full queue
	assign in_stall = q_full;
	assign push     = in_valid & ~q_full;

	// Flood mask: connected ports minus the ingress port, when it is a real port
	always_comb begin
		fmask = port_mask;
		if (32'(in_port) < NUM_PORTS) begin
			fmask = port_mask & ~(MASK_W'(1) << in_port);
		end
	end

	// Decode the request
	always_comb begin
		push_item.op    = cmd ? OP_STATIC : OP_FORWARD;
		push_item.src   = src_id;
		push_item.dst   = dest_id;
		push_item.port  = in_port;
		push_item.fmask = fmask;
	end

endmodule

FILE: sv/lsf_queue.sv
// Short request queue between front and back ends.
// Depends on lsf_pkg.
module lsf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lsf_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output lsf_pkg::item_t head
);
	import lsf_pkg::*;

	item_t             slot_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(Q_DEPTH));
	assign valid   = (cnt_q != '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: sv/lsf_back.sv
// Back end: scans the address table, learns, and forms the result.
// Depends on lsf_pkg and lsf_ram.
module lsf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  lsf_pkg::item_t    q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output lsf_pkg::result_t  out_res,
	output lsf_pkg::status_t  status
);
	import lsf_pkg::*;

	bk_state_t            state_q;
	bk_state_t            state_d;
	item_t                item_q;
	logic [COUNT_W-1:0]   count_q;
	logic [COUNT_W-1:0]   idx_q;
	logic                 rd_pend_q;
	logic                 src_hit_q;
	logic                 dst_hit_q;
	logic [PORT_W-1:0]    dst_port_q;
	logic                 out_valid_q;
	result_t              res_q;

	logic                 ram_re;
	logic                 ram_we;
	logic [ENTRY_W-1:0]   ram_rdata;
	entry_t               rd_entry;
	entry_t               wr_entry;
	logic                 out_free;
	logic                 out_load;
	logic                 need_write;
	logic                 room;
	result_t              res_d;

	assign rd_entry = entry_t'(ram_rdata);
	assign wr_entry = '{id: item_q.src, port: item_q.port};

	lsf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// Result of the finished request
	assign out_free   = ~out_valid_q | ~out_stall;
	assign need_write = (item_q.op == OP_STATIC) | ~src_hit_q;
	assign room       = (count_q < COUNT_W'(TABLE_DEPTH));

	always_comb begin
		res_d            = '0;
		res_d.learned    = need_write & room;
		res_d.table_full = need_write & ~room;
		if (item_q.op == OP_FORWARD) begin
			if (dst_hit_q) begin
				res_d.out_port = dst_port_q;
			end else begin
				res_d.flood      = 1'b1;
				res_d.flood_mask = item_q.fmask;
			end
		end
	end

	// Sequencer: next state and strobes
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = (q_item.op == OP_STATIC) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				// one entry per cycle, oldest first
				if (idx_q < count_q) begin
					ram_re = 1'b1;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					ram_we   = res_d.learned;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rd_pend_q   <= 1'b0;
			src_hit_q   <= 1'b0;
			dst_hit_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= ram_re;
			if (q_pop) begin
				idx_q     <= '0;
				src_hit_q <= 1'b0;
				dst_hit_q <= 1'b0;
			end else if (ram_re) begin
				idx_q <= idx_q + 1'b1;
			end
			// compare the entry read last cycle
			if (rd_pend_q) begin
				if (rd_entry.id == item_q.src) begin
					src_hit_q <= 1'b1;
				end
				if (rd_entry.id == item_q.dst) begin
					dst_hit_q <= 1'b1;
				end
			end
			if (ram_we) begin
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		// newest matching entry wins
		if (rd_pend_q && rd_entry.id == item_q.dst) begin
			dst_port_q <= rd_entry.port;
		end
		if (out_load) begin
			res_q <= res_d;
		end
	end

	assign out_valid          = out_valid_q;
	assign out_res            = res_q;
	assign status.busy        = (state_q != ST_IDLE);
	assign status.entry_count = count_q;

endmodule

FILE: sv/learning_switch_forwarder_unit.sv
// Top level of the learning switch forwarder: config register, front, queue, back.
// Depends on lsf_pkg, lsf_front, lsf_queue, lsf_back and the defines header.
`include "learning_switch_forwarder_unit_defines.svh"

// Learning bridge address table. Each request is either a frame (cmd 0) or a
// static entry (cmd 1) and yields exactly one result. A frame scans the table
// from oldest to newest entry through the single read port of the table RAM,
// one entry per cycle, and a static entry skips the scan. The front end and a
// two-deep request queue keep accepting while the back end scans, until the
// queue is full, and a result register holds a finished result while the next
// request starts. Unknown sources are learned with the ingress port while room
// is left; otherwise table_full is raised. connected_port_mask is written
// through the cfg port, which is always ready; write it only while the block is
// idle.
module learning_switch_forwarder_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lsf_pkg::MASK_W-1:0]   cfg_data,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic [lsf_pkg::ID_WIDTH-1:0] src_id,
	input  logic [lsf_pkg::ID_WIDTH-1:0] dest_id,
	input  logic [lsf_pkg::PORT_W-1:0]   in_port,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lsf_pkg::PORT_W-1:0]   out_port,
	output logic                         flood,
	output logic [lsf_pkg::MASK_W-1:0]   flood_mask,
	output logic                         learned,
	output logic                         table_full
);
	import lsf_pkg::*;

	logic [MASK_W-1:0] port_mask_q;
	logic              push;
	item_t             push_item;
	logic              q_full;
	logic              q_valid;
	item_t             q_head;
	logic              q_pop;
	result_t           res;
	status_t           status;

	// Connected port mask register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			port_mask_q <= cfg_data;
		end
	end

	lsf_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.src_id    (src_id),
		.dest_id   (dest_id),
		.in_port   (in_port),
		.port_mask (port_mask_q),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	lsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	lsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res),
		.status    (status)
	);

	// Result fields
	assign out_port   = res.out_port;
	assign flood      = res.flood;
	assign flood_mask = res.flood_mask;
	assign learned    = res.learned;
	assign table_full = res.table_full;

	// Checks
	`LSF_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, status.entry_count <= COUNT_W'(TABLE_DEPTH))
	`LSF_ASSERT_IMP(a_flood_no_port, clk, arst_n, out_valid && flood, out_port == '0)
	`LSF_ASSERT_IMP(a_learn_xor_full, clk, arst_n, out_valid && learned, !table_full)
	`LSF_ASSERT_NXT(a_pop_spacing, clk, arst_n, q_pop, !q_pop && status.busy)

endmodule

FILE: tb/sv/tb.sv
// Testbench for learning_switch_forwarder_unit: directed and random frame and
// static-entry requests, checked against a bridge table predictor held in a scoreboard.
// Depends on lsf_pkg and the learning_switch_forwarder_unit RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lsf_pkg::*;

	localparam int QUIET_LIMIT     = 5000;
	localparam int LONG_HOLD       = 400;
	localparam int ITEMS_PER_PHASE = 115;
	localparam int POOL_SIZE       = 24;
	localparam int TAIL_CYCLES     = 2 * TABLE_DEPTH + 16;
	localparam int NUM_PHASES      = 5;

	// One request as offered on the input channel
	typedef struct packed {
		op_t                 op;
		logic [ID_WIDTH-1:0] src;
		logic [ID_WIDTH-1:0] dst;
		logic [PORT_W-1:0]   port;
	} request_t;

	// Bridge table predictor plus the queue of forwarding decisions still due
	class fwd_decision_board;
		logic [ID_WIDTH-1:0] station_id[TABLE_DEPTH];
		logic [PORT_W-1:0]   station_port[TABLE_DEPTH];
		int                  station_count = 0;
		logic [MASK_W-1:0]   port_mask = '0;
		result_t             due_decisions[$];
		int                  errors = 0;

		function void set_mask(logic [MASK_W-1:0] mask);
			port_mask = mask;
		endfunction

		function int pending();
			return due_decisions.size();
		endfunction

		// Append an entry while room is left; returns 1 when written
		function bit try_learn(logic [ID_WIDTH-1:0] id, logic [PORT_W-1:0] port);
			if (station_count >= TABLE_DEPTH)
				return 1'b0;
			station_id[station_count]   = id;
			station_port[station_count] = port;
			station_count++;
			return 1'b1;
		endfunction

		// Predict the decision for an accepted request and queue it
		function void accept_request(request_t q);
			result_t             r;
			bit                  src_known;
			bit                  dst_known;
			bit                  room;
			logic [PORT_W-1:0]   dst_port;
			r         = '0;
			src_known = 1'b0;
			dst_known = 1'b0;
			dst_port  = '0;
			if (q.op == OP_STATIC) begin
				room         = try_learn(q.src, q.port);
				r.learned    = room;
				r.table_full = !room;
			end else begin
				// lookup sees the table as it stood before this frame;
				// the newest matching entry wins for the destination
				for (int i = 0; i < station_count; i++) begin
					if (station_id[i] == q.src)
						src_known = 1'b1;
					if (station_id[i] == q.dst) begin
						dst_known = 1'b1;
						dst_port  = station_port[i];
					end
				end
				if (!src_known) begin
					room         = try_learn(q.src, q.port);
					r.learned    = room;
					r.table_full = !room;
				end
				if (dst_known) begin
					r.out_port = dst_port;
				end else begin
					r.flood      = 1'b1;
					r.flood_mask = port_mask;
					if (int'(q.port) < NUM_PORTS)
						r.flood_mask[q.port] = 1'b0;
				end
			end
			due_decisions.insert(due_decisions.size(), r);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t MISMATCH %s expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Compare an accepted result with the oldest decision due
		function void check_decision(result_t got);
			result_t want;
			if (due_decisions.size() == 0) begin
				$display("%0t MISMATCH unrequested result expected none actual %0h",
					$time, got);
				errors++;
			end else begin
				want = due_decisions.pop_front();
				check_field("out_port", want.out_port, got.out_port);
				check_field("flood", want.flood, got.flood);
				check_field("flood_mask", want.flood_mask, got.flood_mask);
				check_field("learned", want.learned, got.learned);
				check_field("table_full", want.table_full, got.table_full);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [MASK_W-1:0]   cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                cmd = 1'b0;
	logic [ID_WIDTH-1:0] src_id = '0;
	logic [ID_WIDTH-1:0] dest_id = '0;
	logic [PORT_W-1:0]   in_port = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [PORT_W-1:0]   out_port;
	logic                flood;
	logic [MASK_W-1:0]   flood_mask;
	logic                learned;
	logic                table_full;

	fwd_decision_board   board;
	logic [ID_WIDTH-1:0] id_pool[POOL_SIZE];
	bit                  tx_idle_on = 1'b1;
	bit                  rx_idle_on = 1'b1;
	bit                  long_hold = 1'b0;

	learning_switch_forwarder_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.src_id     (src_id),
		.dest_id    (dest_id),
		.in_port    (in_port),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_port   (out_port),
		.flood      (flood),
		.flood_mask (flood_mask),
		.learned    (learned),
		.table_full (table_full)
	);

	always #5 clk = ~clk;

	function automatic request_t make_req(op_t op, logic [ID_WIDTH-1:0] src,
		logic [ID_WIDTH-1:0] dst, logic [PORT_W-1:0] port);
		request_t q;
		q.op   = op;
		q.src  = src;
		q.dst  = dst;
		q.port = port;
		return q;
	endfunction

	// Mostly pool IDs so lookups hit; some fresh IDs keep the table filling
	function automatic request_t random_request();
		request_t q;
		int       sel;
		q.op  = ($urandom_range(0, 99) < 8) ? OP_STATIC : OP_FORWARD;
		q.src = ($urandom_range(0, 99) < 80) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
			: ID_WIDTH'($urandom);
		sel = $urandom_range(0, 9);
		if (sel < 8)
			q.dst = id_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (sel == 8)
			q.dst = ID_WIDTH'($urandom);
		else
			q.dst = q.src;
		q.port = PORT_W'($urandom_range(0, 15));
		return q;
	endfunction

	// Offer one request and hold it until accepted; in_valid stays high
	task automatic send_request(request_t q);
		in_valid <= 1'b1;
		cmd      <= q.op;
		src_id   <= q.src;
		dest_id  <= q.dst;
		in_port  <= q.port;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.accept_request(q);
	endtask

	// Random sender gap
	task automatic sender_gap();
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every outstanding result
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_port_mask(logic [MASK_W-1:0] mask);
		cfg_valid <= 1'b1;
		cfg_data  <= mask;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		board.set_mask(mask);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random_phase(int count);
		for (int k = 0; k < count; k++) begin
			sender_gap();
			send_request(random_request());
			if ($urandom_range(0, 59) == 0)
				wait_drained();
		end
	endtask

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
			board.check_decision(result_t'({out_port, flood, flood_mask, learned, table_full}));
	end

	// Receiver stall: random bursts, or one long hold-off on request
	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 14);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: too many cycles without any handshake
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid & ~in_stall) === 1'b1 || (out_valid & ~out_stall) === 1'b1
				|| (cfg_valid & cfg_ready) === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		logic [MASK_W-1:0] phase_mask[NUM_PHASES];
		board = new;
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			id_pool[i] = ID_WIDTH'($urandom);
		phase_mask[0] = '0;
		phase_mask[1] = MASK_W'($urandom);
		phase_mask[2] = '1;
		phase_mask[3] = MASK_W'($urandom);
		phase_mask[4] = MASK_W'($urandom);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flood with the reset mask of no connected ports
		send_request(make_req(OP_FORWARD, 16'h0000, 16'hFFFF, 4'd0));
		wait_drained();
		write_port_mask(16'hFFFF);

		// learning, known source not moved, source equal to unknown destination
		send_request(make_req(OP_FORWARD, 16'hFFFF, 16'h0000, 4'd15));
		send_request(make_req(OP_FORWARD, 16'hFFFF, 16'hFFFF, 4'd3));
		send_request(make_req(OP_FORWARD, 16'h1234, 16'h1234, 4'd5));
		// duplicate static entry: newest match gives the port
		send_request(make_req(OP_STATIC, 16'h0000, 16'h0000, 4'd9));
		send_request(make_req(OP_FORWARD, 16'h0001, 16'h0000, 4'd1));
		send_request(make_req(OP_FORWARD, 16'h0002, 16'h0001, 4'd2));
		// destination sits on the ingress port
		send_request(make_req(OP_FORWARD, 16'h0003, 16'h0002, 4'd2));
		send_request(make_req(OP_STATIC, 16'hA5A5, 16'hFFFF, 4'd15));
		send_request(make_req(OP_STATIC, 16'h5A5A, 16'h0000, 4'd0));
		send_request(make_req(OP_FORWARD, 16'hA5A5, 16'h5A5A, 4'd7));
		send_request(make_req(OP_FORWARD, 16'h8000, 16'h7FFF, 4'd8));
		wait_drained();

		// destination on an unconnected port
		write_port_mask(16'h00FF);
		send_request(make_req(OP_FORWARD, 16'h5A5A, 16'hA5A5, 4'd3));
		send_request(make_req(OP_FORWARD, 16'h7FFF, 16'hBEEF, 4'd4));
		wait_drained();

		// random phases, one mask each; the last runs with no idling
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_port_mask(phase_mask[p]);
			if (p == NUM_PHASES - 1) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			if (p == 1) begin
				// long receiver hold-off while requests keep coming
				long_hold = 1'b1;
				repeat (20) send_request(random_request());
			end
			run_random_phase(ITEMS_PER_PHASE);
			wait_drained();
		end

		// full table: static and unknown source both report full
		send_request(make_req(OP_STATIC, 16'hC0DE, 16'h0000, 4'd6));
		send_request(make_req(OP_FORWARD, ID_WIDTH'($urandom), id_pool[1], 4'd11));
		send_request(make_req(OP_FORWARD, 16'h0000, 16'hFFFF, 4'd15));

		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
